// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the ball physics step unit.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BBPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BBPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/bbps_pkg.sv =====
// Shared types, widths and codes for the ball physics step unit.
// No dependencies.
package bbps_pkg;

    localparam int MAX_BALLS_DEF  = 32;
    localparam int NUM_COLORS_DEF = 14;

    localparam int POS_W      = 21;
    localparam int VEL_W      = 16;
    localparam int RAD_W      = 8;
    localparam int COL_W      = 4;
    localparam int FADE_W     = 16;
    localparam int DT_W       = 20;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 6;
    localparam int SM_W       = 16;
    localparam int FS_W       = 24;
    localparam int SCR_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BALL_COUNT    = 3'd0,
        CFG_SPEED_MULT    = 3'd1,
        CFG_FADE_SPEED    = 3'd2,
        CFG_SCREEN_WIDTH  = 3'd3,
        CFG_SCREEN_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic [RAD_W-1:0]        r;
        logic [COL_W-1:0]        c;
        logic [COL_W-1:0]        nc;
        logic [FADE_W-1:0]       f;
    } ball_t;

    typedef enum logic [4:0] {
        OP_NONE     = 5'd0,
        OP_LOAD     = 5'd1,
        OP_START    = 5'd2,
        OP_MV_CAP   = 5'd3,
        OP_MV_MUL   = 5'd4,
        OP_MV_RND   = 5'd5,
        OP_MV_POS   = 5'd6,
        OP_MV_WB    = 5'd7,
        OP_PR_CAPA  = 5'd8,
        OP_PR_CAPB  = 5'd9,
        OP_PR_SQ    = 5'd10,
        OP_PR_CMP   = 5'd11,
        OP_PR_OV    = 5'd12,
        OP_PR_MUL   = 5'd13,
        OP_PR_DIVX  = 5'd14,
        OP_PR_PX    = 5'd15,
        OP_PR_PY    = 5'd16,
        OP_PR_PUSH  = 5'd17,
        OP_PR_WBA   = 5'd18,
        OP_PR_WBB   = 5'd19,
        OP_EM_LD    = 5'd20
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [IDX_W-1:0]  addr;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic             collide;
        logic             dsq_zero;
        logic             sq_done;
        logic             div_done;
    } stat_t;

endpackage

// ===== rtl/core/bbps_dp.sv =====
// Datapath of the ball physics step unit: config registers, ball memory,
// move/bounce/fade arithmetic, pair test, iterative square root and divider.
// Depends on bbps_pkg.
module bbps_dp #(
    parameter int MAX_BALLS  = bbps_pkg::MAX_BALLS_DEF,
    parameter int NUM_COLORS = bbps_pkg::NUM_COLORS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bbps_pkg::cmd_t                      cmd,
    output bbps_pkg::stat_t                     stat,
    input  logic                                cfg_we,
    input  logic [bbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [bbps_pkg::IDX_W-1:0]          ball_index,
    input  logic signed [bbps_pkg::POS_W-1:0]   pos_x,
    input  logic signed [bbps_pkg::POS_W-1:0]   pos_y,
    input  logic signed [bbps_pkg::VEL_W-1:0]   vel_x,
    input  logic signed [bbps_pkg::VEL_W-1:0]   vel_y,
    input  logic [bbps_pkg::RAD_W-1:0]          radius,
    input  logic [bbps_pkg::COL_W-1:0]          color_index,
    input  logic [bbps_pkg::DT_W-1:0]           delta_time,
    output logic [bbps_pkg::IDX_W-1:0]          out_index,
    output logic signed [bbps_pkg::POS_W-1:0]   out_x,
    output logic signed [bbps_pkg::POS_W-1:0]   out_y,
    output logic [bbps_pkg::RAD_W-1:0]          out_radius,
    output logic [bbps_pkg::COL_W-1:0]          out_color,
    output logic [bbps_pkg::COL_W-1:0]          out_next_color,
    output logic [bbps_pkg::FADE_W-1:0]         out_fade,
    output logic                                last
);
    import bbps_pkg::*;

    localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [25:0] v);
        logic signed [25:0] lo;
        logic signed [25:0] hi;
        lo = -26'sd1048576;
        hi = 26'sd1048575;
        if (v < lo) begin
            return lo[POS_W-1:0];
        end
        if (v > hi) begin
            return hi[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
        if (v == {1'b1, {(VEL_W-1){1'b0}}}) begin
            return {1'b0, {(VEL_W-1){1'b1}}};
        end
        return -v;
    endfunction

    function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] c);
        if (c == COL_W'(NUM_COLORS - 1)) begin
            return '0;
        end
        return c + 1'b1;
    endfunction

    function automatic logic signed [24:0] rnd30(input logic signed [53:0] p);
        logic [53:0] mag;
        logic [53:0] m;
        mag = p[53] ? 54'(-p) : 54'(p);
        m = (mag + (54'd1 << 29)) >> 30;
        return p[53] ? -$signed(m[24:0]) : $signed(m[24:0]);
    endfunction

    function automatic void bounce(
        input  logic signed [POS_W-1:0] p,
        input  logic signed [VEL_W-1:0] v,
        input  logic [RAD_W-1:0]        r,
        input  logic [SCR_W-1:0]        w,
        output logic signed [POS_W-1:0] po,
        output logic signed [VEL_W-1:0] vo
    );
        logic signed [22:0] p23;
        logic signed [22:0] r8;
        logic signed [22:0] w8;
        logic signed [22:0] d;
        p23 = {{2{p[POS_W-1]}}, p};
        r8  = {7'd0, r, 8'd0};
        w8  = {3'd0, w, 8'd0};
        d   = w8 - r8;
        po  = p;
        vo  = v;
        if (p23 <= r8) begin
            po = r8[POS_W-1:0];
            vo = neg_vel(v);
        end else if (p23 + r8 >= w8) begin
            po = d[POS_W-1:0];
            vo = neg_vel(v);
        end
    endfunction

    // config
    logic [CNT_W-1:0] bc_reg;
    logic [SM_W-1:0]  sm_reg;
    logic [FS_W-1:0]  fs_reg;
    logic [SCR_W-1:0] sw_reg;
    logic [SCR_W-1:0] sh_reg;

    // tick context
    logic [CNT_W-1:0] n_reg;
    logic [DT_W-1:0]  dt_reg;
    logic [43:0]      fprod_reg;
    logic [27:0]      fstep_reg;

    ball_t mem [MAX_BALLS];
    ball_t rdata_reg;
    ball_t a_reg;
    ball_t b_reg;

    logic signed [32:0] p1x_reg, p1y_reg;
    logic signed [53:0] p2x_reg, p2y_reg;
    logic signed [24:0] stx_reg, sty_reg;

    logic signed [21:0] dx_reg, dy_reg;
    logic [16:0]        md_reg;
    logic [43:0]        dxsq_reg, dysq_reg;
    logic [33:0]        mdsq_reg;

    logic [45:0] sq_v_reg;
    logic [24:0] sq_rem_reg;
    logic [22:0] sq_root_reg;
    logic [4:0]  sq_cnt_reg;

    logic [16:0] ov_reg;
    logic [38:0] ovdx_reg, ovdy_reg;

    logic [39:0] dv_q_reg;
    logic [23:0] dv_rem_reg;
    logic [23:0] dv_div_reg;
    logic [5:0]  dv_cnt_reg;

    logic signed [17:0] px_reg, py_reg;

    // combinational helpers
    logic [44:0]        dsq;
    logic [COL_W-1:0]   ld_col;
    ball_t              ld_rec;
    ball_t              mv_rec;
    logic [28:0]        fsum;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    ball_t              wr_data;
    logic [26:0]        sq_r;
    logic [26:0]        sq_t;
    logic [24:0]        dv_r;
    logic [21:0]        absdx, absdy;
    logic signed [17:0] q_s;
    logic signed [43:0] dxsq_s, dysq_s;
    logic [CNT_W-1:0]   n_sat;

    assign dsq    = {1'b0, dxsq_reg} + {1'b0, dysq_reg};
    assign absdx  = dx_reg[21] ? 22'(-dx_reg) : 22'(dx_reg);
    assign absdy  = dy_reg[21] ? 22'(-dy_reg) : 22'(dy_reg);
    assign q_s    = $signed({1'b0, dv_q_reg[16:0]});
    assign dxsq_s = dx_reg * dx_reg;
    assign dysq_s = dy_reg * dy_reg;
    assign n_sat  = (bc_reg > CNT_W'(MAX_BALLS)) ? CNT_W'(MAX_BALLS) : bc_reg;

    assign stat.n        = n_reg;
    assign stat.collide  = dsq < {11'd0, mdsq_reg};
    assign stat.dsq_zero = (dsq == '0);
    assign stat.sq_done  = (sq_cnt_reg == '0);
    assign stat.div_done = (dv_cnt_reg == '0);

    always_comb
    begin
        ld_col = color_index;
        for (int s = 0; s < 8; s++)
        begin
            if (ld_col >= COL_W'(NUM_COLORS)) begin
                ld_col = ld_col - COL_W'(NUM_COLORS);
            end
        end
        ld_rec.x  = pos_x;
        ld_rec.y  = pos_y;
        ld_rec.vx = vel_x;
        ld_rec.vy = vel_y;
        ld_rec.r  = radius;
        ld_rec.c  = ld_col;
        ld_rec.nc = next_col(ld_col);
        ld_rec.f  = '0;
    end

    always_comb
    begin
        mv_rec = a_reg;
        bounce(a_reg.x, a_reg.vx, a_reg.r, sw_reg, mv_rec.x, mv_rec.vx);
        bounce(a_reg.y, a_reg.vy, a_reg.r, sh_reg, mv_rec.y, mv_rec.vy);
        fsum = {13'd0, a_reg.f} + {1'b0, fstep_reg};
        if (fsum[28:16] != '0) begin
            mv_rec.f  = '0;
            mv_rec.c  = a_reg.nc;
            mv_rec.nc = next_col(a_reg.nc);
        end else begin
            mv_rec.f  = fsum[15:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd.addr;
        wr_data = a_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                wr_en   = ({1'b0, ball_index} < (IDX_W+1)'(MAX_BALLS));
                wr_addr = ball_index;
                wr_data = ld_rec;
            end
            OP_MV_WB:
            begin
                wr_en   = 1'b1;
                wr_data = mv_rec;
            end
            OP_PR_WBA:
            begin
                wr_en   = 1'b1;
                wr_data = a_reg;
            end
            OP_PR_WBB:
            begin
                wr_en   = 1'b1;
                wr_data = b_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign sq_r = {sq_rem_reg, sq_v_reg[45:44]};
    assign sq_t = {2'b00, sq_root_reg, 2'b01};
    assign dv_r = {dv_rem_reg, dv_q_reg[39]};

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        rdata_reg <= mem[cmd.addr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bc_reg     <= CNT_W'(16);
            sm_reg     <= SM_W'(256);
            fs_reg     <= FS_W'(6554);
            sw_reg     <= SCR_W'(1920);
            sh_reg     <= SCR_W'(1080);
            n_reg      <= '0;
            sq_cnt_reg <= '0;
            dv_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BALL_COUNT:    bc_reg <= cfg_data[CNT_W-1:0];
                    CFG_SPEED_MULT:    sm_reg <= cfg_data[SM_W-1:0];
                    CFG_FADE_SPEED:    fs_reg <= cfg_data[FS_W-1:0];
                    CFG_SCREEN_WIDTH:  sw_reg <= cfg_data[SCR_W-1:0];
                    CFG_SCREEN_HEIGHT: sh_reg <= cfg_data[SCR_W-1:0];
                    default:           bc_reg <= bc_reg;
                endcase
            end
            if (cmd.op == OP_START) begin
                n_reg <= n_sat;
            end
            if (cmd.op == OP_PR_CMP) begin
                sq_cnt_reg <= 5'd23;
            end else if (sq_cnt_reg != '0) begin
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
            end
            if (cmd.op == OP_PR_DIVX || cmd.op == OP_PR_PX) begin
                dv_cnt_reg <= 6'd40;
            end else if (dv_cnt_reg != '0) begin
                dv_cnt_reg <= dv_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fstep_reg <= 28'((fprod_reg + 44'd32768) >> 16);
        if (cmd.op == OP_PR_CMP) begin
            sq_v_reg    <= {1'b0, dsq};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end else if (sq_cnt_reg != '0) begin
            if (sq_r >= sq_t) begin
                sq_rem_reg  <= 25'(sq_r - sq_t);
                sq_root_reg <= {sq_root_reg[21:0], 1'b1};
            end else begin
                sq_rem_reg  <= sq_r[24:0];
                sq_root_reg <= {sq_root_reg[21:0], 1'b0};
            end
            sq_v_reg <= {sq_v_reg[43:0], 2'b00};
        end
        if (cmd.op == OP_PR_DIVX) begin
            dv_q_reg   <= {1'b0, ovdx_reg} + {17'd0, sq_root_reg};
            dv_div_reg <= {sq_root_reg, 1'b0};
            dv_rem_reg <= '0;
        end else if (cmd.op == OP_PR_PX) begin
            dv_q_reg   <= {1'b0, ovdy_reg} + {17'd0, sq_root_reg};
            dv_rem_reg <= '0;
        end else if (dv_cnt_reg != '0) begin
            if (dv_r >= {1'b0, dv_div_reg}) begin
                dv_rem_reg <= 24'(dv_r - {1'b0, dv_div_reg});
                dv_q_reg   <= {dv_q_reg[38:0], 1'b1};
            end else begin
                dv_rem_reg <= dv_r[23:0];
                dv_q_reg   <= {dv_q_reg[38:0], 1'b0};
            end
        end
        case (cmd.op)
            OP_START:
            begin
                dt_reg    <= delta_time;
                fprod_reg <= fs_reg * delta_time;
            end
            OP_MV_CAP:
            begin
                a_reg   <= rdata_reg;
                p1x_reg <= rdata_reg.vx * $signed({1'b0, sm_reg});
                p1y_reg <= rdata_reg.vy * $signed({1'b0, sm_reg});
            end
            OP_MV_MUL:
            begin
                p2x_reg <= p1x_reg * $signed({1'b0, dt_reg});
                p2y_reg <= p1y_reg * $signed({1'b0, dt_reg});
            end
            OP_MV_RND:
            begin
                stx_reg <= rnd30(p2x_reg);
                sty_reg <= rnd30(p2y_reg);
            end
            OP_MV_POS:
            begin
                a_reg.x <= sat_pos({{5{a_reg.x[POS_W-1]}}, a_reg.x}
                                   + {{1{stx_reg[24]}}, stx_reg});
                a_reg.y <= sat_pos({{5{a_reg.y[POS_W-1]}}, a_reg.y}
                                   + {{1{sty_reg[24]}}, sty_reg});
            end
            OP_PR_CAPA:
            begin
                a_reg <= rdata_reg;
            end
            OP_PR_CAPB:
            begin
                b_reg  <= rdata_reg;
                dx_reg <= {a_reg.x[POS_W-1], a_reg.x} - {rdata_reg.x[POS_W-1], rdata_reg.x};
                dy_reg <= {a_reg.y[POS_W-1], a_reg.y} - {rdata_reg.y[POS_W-1], rdata_reg.y};
                md_reg <= {({1'b0, a_reg.r} + {1'b0, rdata_reg.r}), 8'd0};
            end
            OP_PR_SQ:
            begin
                dxsq_reg <= dxsq_s;
                dysq_reg <= dysq_s;
                mdsq_reg <= md_reg * md_reg;
            end
            OP_PR_CMP:
            begin
                if (stat.collide) begin
                    a_reg.vx <= b_reg.vx;
                    a_reg.vy <= b_reg.vy;
                    b_reg.vx <= a_reg.vx;
                    b_reg.vy <= a_reg.vy;
                end
            end
            OP_PR_OV:
            begin
                ov_reg <= md_reg - sq_root_reg[16:0];
            end
            OP_PR_MUL:
            begin
                ovdx_reg <= ov_reg * absdx;
                ovdy_reg <= ov_reg * absdy;
            end
            OP_PR_PX:
            begin
                px_reg <= dx_reg[21] ? -q_s : q_s;
            end
            OP_PR_PY:
            begin
                py_reg <= dy_reg[21] ? -q_s : q_s;
            end
            OP_PR_PUSH:
            begin
                a_reg.x <= sat_pos({{5{a_reg.x[POS_W-1]}}, a_reg.x}
                                   + {{8{px_reg[17]}}, px_reg});
                a_reg.y <= sat_pos({{5{a_reg.y[POS_W-1]}}, a_reg.y}
                                   + {{8{py_reg[17]}}, py_reg});
                b_reg.x <= sat_pos({{5{b_reg.x[POS_W-1]}}, b_reg.x}
                                   - {{8{px_reg[17]}}, px_reg});
                b_reg.y <= sat_pos({{5{b_reg.y[POS_W-1]}}, b_reg.y}
                                   - {{8{py_reg[17]}}, py_reg});
            end
            OP_EM_LD:
            begin
                out_index      <= cmd.addr;
                out_x          <= rdata_reg.x;
                out_y          <= rdata_reg.y;
                out_radius     <= rdata_reg.r;
                out_color      <= rdata_reg.c;
                out_next_color <= rdata_reg.nc;
                out_fade       <= rdata_reg.f;
                last           <= cmd.last;
            end
            default:
            begin
                dt_reg <= dt_reg;
            end
        endcase
    end

endmodule

// ===== rtl/core/bbps_ctrl.sv =====
// Sequencer of the ball physics step unit: move pass, pair pass, emit pass.
// Depends on bbps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bbps_ctrl #(
    parameter int MAX_BALLS = bbps_pkg::MAX_BALLS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             opcode,
    output logic             out_valid,
    input  logic             out_stall,
    output bbps_pkg::cmd_t   cmd,
    input  bbps_pkg::stat_t  stat
);
    import bbps_pkg::*;

    localparam int CW   = $clog2(MAX_BALLS + 1);
    localparam int ST_W = 29;

    typedef enum logic [ST_W-1:0] {
        S_IDLE    = ST_W'(1) << 0,
        S_TK_CHK  = ST_W'(1) << 1,
        S_MV_RD   = ST_W'(1) << 2,
        S_MV_CAP  = ST_W'(1) << 3,
        S_MV_MUL  = ST_W'(1) << 4,
        S_MV_RND  = ST_W'(1) << 5,
        S_MV_POS  = ST_W'(1) << 6,
        S_MV_WB   = ST_W'(1) << 7,
        S_PR_INIT = ST_W'(1) << 8,
        S_PR_RDI  = ST_W'(1) << 9,
        S_PR_RDJ  = ST_W'(1) << 10,
        S_PR_CAPJ = ST_W'(1) << 11,
        S_PR_SQ   = ST_W'(1) << 12,
        S_PR_CMP  = ST_W'(1) << 13,
        S_PR_SQRT = ST_W'(1) << 14,
        S_PR_OV   = ST_W'(1) << 15,
        S_PR_MUL  = ST_W'(1) << 16,
        S_PR_DXS  = ST_W'(1) << 17,
        S_PR_DIVX = ST_W'(1) << 18,
        S_PR_PX   = ST_W'(1) << 19,
        S_PR_DIVY = ST_W'(1) << 20,
        S_PR_PY   = ST_W'(1) << 21,
        S_PR_PUSH = ST_W'(1) << 22,
        S_PR_WBA  = ST_W'(1) << 23,
        S_PR_WBB  = ST_W'(1) << 24,
        S_PR_NEXT = ST_W'(1) << 25,
        S_EM_RD   = ST_W'(1) << 26,
        S_EM_LD   = ST_W'(1) << 27,
        S_EM_HOLD = ST_W'(1) << 28
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           out_valid_reg, out_valid_next;
    logic [CW-1:0]  n_c;
    logic [CW:0]    i_inc, j_inc, n_w;
    logic           last_k;

    assign n_c    = CW'(stat.n);
    assign n_w    = {1'b0, n_c};
    assign i_inc  = {1'b0, i_reg} + 1'b1;
    assign j_inc  = {1'b0, j_reg} + 1'b1;
    assign last_k = ({1'b0, k_reg} + 1'b1) == n_w;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        cmd.addr       = '0;
        cmd.last       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    if (opcode == OPC_TICK) begin
                        cmd.op     = OP_START;
                        state_next = S_TK_CHK;
                    end else begin
                        cmd.op = OP_LOAD;
                    end
                end
            end
            S_TK_CHK:
            begin
                i_next     = '0;
                state_next = (n_c == '0) ? S_IDLE : S_MV_RD;
            end
            S_MV_RD:
            begin
                cmd.addr   = IDX_W'(i_reg);
                state_next = S_MV_CAP;
            end
            S_MV_CAP:
            begin
                cmd.op     = OP_MV_CAP;
                state_next = S_MV_MUL;
            end
            S_MV_MUL:
            begin
                cmd.op     = OP_MV_MUL;
                state_next = S_MV_RND;
            end
            S_MV_RND:
            begin
                cmd.op     = OP_MV_RND;
                state_next = S_MV_POS;
            end
            S_MV_POS:
            begin
                cmd.op     = OP_MV_POS;
                state_next = S_MV_WB;
            end
            S_MV_WB:
            begin
                cmd.op   = OP_MV_WB;
                cmd.addr = IDX_W'(i_reg);
                i_next   = i_inc[CW-1:0];
                if (i_inc == n_w) begin
                    state_next = S_PR_INIT;
                end else begin
                    state_next = S_MV_RD;
                end
            end
            S_PR_INIT:
            begin
                i_next = '0;
                j_next = CW'(1);
                k_next = '0;
                state_next = (n_w < (CW+1)'(2)) ? S_EM_RD : S_PR_RDI;
            end
            S_PR_RDI:
            begin
                cmd.addr   = IDX_W'(i_reg);
                state_next = S_PR_RDJ;
            end
            S_PR_RDJ:
            begin
                cmd.op     = OP_PR_CAPA;
                cmd.addr   = IDX_W'(j_reg);
                state_next = S_PR_CAPJ;
            end
            S_PR_CAPJ:
            begin
                cmd.op     = OP_PR_CAPB;
                state_next = S_PR_SQ;
            end
            S_PR_SQ:
            begin
                cmd.op     = OP_PR_SQ;
                state_next = S_PR_CMP;
            end
            S_PR_CMP:
            begin
                cmd.op = OP_PR_CMP;
                if (!stat.collide) begin
                    state_next = S_PR_NEXT;
                end else if (stat.dsq_zero) begin
                    state_next = S_PR_WBA;
                end else begin
                    state_next = S_PR_SQRT;
                end
            end
            S_PR_SQRT:
            begin
                if (stat.sq_done) begin
                    state_next = S_PR_OV;
                end
            end
            S_PR_OV:
            begin
                cmd.op     = OP_PR_OV;
                state_next = S_PR_MUL;
            end
            S_PR_MUL:
            begin
                cmd.op     = OP_PR_MUL;
                state_next = S_PR_DXS;
            end
            S_PR_DXS:
            begin
                cmd.op     = OP_PR_DIVX;
                state_next = S_PR_DIVX;
            end
            S_PR_DIVX:
            begin
                if (stat.div_done) begin
                    state_next = S_PR_PX;
                end
            end
            S_PR_PX:
            begin
                cmd.op     = OP_PR_PX;
                state_next = S_PR_DIVY;
            end
            S_PR_DIVY:
            begin
                if (stat.div_done) begin
                    state_next = S_PR_PY;
                end
            end
            S_PR_PY:
            begin
                cmd.op     = OP_PR_PY;
                state_next = S_PR_PUSH;
            end
            S_PR_PUSH:
            begin
                cmd.op     = OP_PR_PUSH;
                state_next = S_PR_WBA;
            end
            S_PR_WBA:
            begin
                cmd.op     = OP_PR_WBA;
                cmd.addr   = IDX_W'(i_reg);
                state_next = S_PR_WBB;
            end
            S_PR_WBB:
            begin
                cmd.op     = OP_PR_WBB;
                cmd.addr   = IDX_W'(j_reg);
                state_next = S_PR_NEXT;
            end
            S_PR_NEXT:
            begin
                if (j_inc < n_w) begin
                    j_next     = j_inc[CW-1:0];
                    state_next = S_PR_RDI;
                end else if (({1'b0, i_reg} + (CW+1)'(2)) < n_w) begin
                    i_next     = i_inc[CW-1:0];
                    j_next     = CW'({1'b0, i_reg} + (CW+1)'(2));
                    state_next = S_PR_RDI;
                end else begin
                    k_next     = '0;
                    state_next = S_EM_RD;
                end
            end
            S_EM_RD:
            begin
                cmd.addr   = IDX_W'(k_reg);
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                cmd.op         = OP_EM_LD;
                cmd.addr       = IDX_W'(k_reg);
                cmd.last       = last_k;
                out_valid_next = 1'b1;
                state_next     = S_EM_HOLD;
            end
            S_EM_HOLD:
            begin
                if (!out_stall) begin
                    out_valid_next = 1'b0;
                    if (last_k) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = CW'({1'b0, k_reg} + 1'b1);
                        state_next = S_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BBPS_ASSERT_IMPL(a_out_only_in_hold, clk, rst_n, out_valid_reg, state_reg == S_EM_HOLD, "beat shown outside emit hold")
    `BBPS_ASSERT_IMPL(a_pair_order, clk, rst_n, state_reg == S_PR_RDI, (i_reg < j_reg) && (j_reg < n_c), "pair indices out of order")
    `BBPS_ASSERT_IMPL(a_move_range, clk, rst_n, state_reg == S_MV_RD, i_reg < n_c, "move index beyond ball count")
    `BBPS_ASSERT_NEXT(a_last_to_idle, clk, rst_n, (state_reg == S_EM_HOLD) && !out_stall && last_k, state_reg == S_IDLE, "tick did not end after last beat")

endmodule

// ===== rtl/core/bouncing_ball_physics_step_unit.sv =====
// Top level of the ball physics step unit: sequencer plus datapath.
// Depends on bbps_pkg, bbps_ctrl and bbps_dp.
//
// Input channel (in_valid/in_stall): a load beat writes one ball slot; a tick
// beat moves, bounces and fades the first ball_count balls, resolves all
// pairs i<j, then sends one output beat per ball in slot order, last set on
// the final one. in_stall stays high until the final beat of a tick is
// taken; ticks with ball_count zero send no output beats.
// Tick work: a move pass over the balls, a test of every pair, and for each
// touching pair at nonzero distance a 23-step square root and two 40-step
// divisions (one bit each cycle); then the output beats, held while the
// receiver stalls.
// All ball state lives in one single-write-port memory, so pair work is
// serial. Output beats sit in a register; out_stall simply holds the beat.
// cfg_valid/cfg_ready writes a register by index; cfg_ready is always high
// and writes belong in idle time between items.
// Reset restores register defaults and idles the sequencer; ball slots hold
// nothing useful until loaded.
module bouncing_ball_physics_step_unit #(
    parameter int MAX_BALLS  = bbps_pkg::MAX_BALLS_DEF,
    parameter int NUM_COLORS = bbps_pkg::NUM_COLORS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [bbps_pkg::IDX_W-1:0]          ball_index,
    input  logic signed [bbps_pkg::POS_W-1:0]   pos_x,
    input  logic signed [bbps_pkg::POS_W-1:0]   pos_y,
    input  logic signed [bbps_pkg::VEL_W-1:0]   vel_x,
    input  logic signed [bbps_pkg::VEL_W-1:0]   vel_y,
    input  logic [bbps_pkg::RAD_W-1:0]          radius,
    input  logic [bbps_pkg::COL_W-1:0]          color_index,
    input  logic [bbps_pkg::DT_W-1:0]           delta_time,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bbps_pkg::IDX_W-1:0]          out_index,
    output logic signed [bbps_pkg::POS_W-1:0]   out_x,
    output logic signed [bbps_pkg::POS_W-1:0]   out_y,
    output logic [bbps_pkg::RAD_W-1:0]          out_radius,
    output logic [bbps_pkg::COL_W-1:0]          out_color,
    output logic [bbps_pkg::COL_W-1:0]          out_next_color,
    output logic [bbps_pkg::FADE_W-1:0]         out_fade,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bbps_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    bbps_ctrl #(
        .MAX_BALLS (MAX_BALLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    bbps_dp #(
        .MAX_BALLS  (MAX_BALLS),
        .NUM_COLORS (NUM_COLORS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ball_index     (ball_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .radius         (radius),
        .color_index    (color_index),
        .delta_time     (delta_time),
        .out_index      (out_index),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_radius     (out_radius),
        .out_color      (out_color),
        .out_next_color (out_next_color),
        .out_fade       (out_fade),
        .last           (last)
    );

endmodule
